@@ src/pcg_pkg.sv @@
package pcg_pkg;

	localparam int MAX_CELLS = 1024;
	localparam int MAX_DIM = 64;
	localparam int ADDR_W = $clog2(MAX_CELLS);

	localparam int CELL_W = 3;
	localparam int IDX_W = 6;
	localparam int COUNT_W = 7;
	localparam int POS_W = 7;
	localparam int FUNC_W = 3;
	localparam int STATUS_W = 3;

	localparam int OP_W = COUNT_W + 1;
	localparam int PROD_W = 2 * OP_W;

	localparam int IN_BITS = 2 * IDX_W + POS_W + CELL_W + 2 * COUNT_W;
	localparam int IN_W = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = CELL_W + 2 * COUNT_W;
	localparam int OUT_W = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [FUNC_W-1:0] {
		FN_READ    = 3'd0,
		FN_WRITE   = 3'd1,
		FN_INIT    = 3'd2,
		FN_INS_ROW = 3'd3,
		FN_DEL_ROW = 3'd4,
		FN_INS_COL = 3'd5,
		FN_DEL_COL = 3'd6
	} func_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_BAD_POS   = 3'd1,
		ST_LAST      = 3'd2,
		ST_CAPACITY  = 3'd3,
		ST_BAD_COORD = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		WK_CLEAR,
		WK_INS_ROW,
		WK_DEL_ROW,
		WK_INS_COL,
		WK_DEL_COL
	} walk_kind_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_READ,
		S_WALK,
		S_DRAIN
	} state_t;

	typedef struct packed {
		logic [IN_W-IN_BITS-1:0] pad;
		logic [COUNT_W-1:0]      dim_cols;
		logic [COUNT_W-1:0]      dim_rows;
		logic [CELL_W-1:0]       value;
		logic [POS_W-1:0]        position;
		logic [IDX_W-1:0]        column;
		logic [IDX_W-1:0]        row;
	} in_word_t;

	typedef struct packed {
		logic [OUT_W-OUT_BITS-1:0] pad;
		logic [COUNT_W-1:0]        cols_now;
		logic [COUNT_W-1:0]        rows_now;
		logic [CELL_W-1:0]         read_value;
	} out_word_t;

	typedef struct packed {
		walk_kind_t         kind;
		logic               desc;
		logic [IDX_W-1:0]   r_start;
		logic [IDX_W-1:0]   r_end;
		logic [COUNT_W-1:0] cn;
		logic [COUNT_W-1:0] co;
		logic [POS_W-1:0]   pos;
		logic [CELL_W-1:0]  fill;
		logic [ADDR_W-1:0]  dst_base;
		logic [ADDR_W-1:0]  src_base;
	} walk_plan_t;

	typedef struct packed {
		status_t            status;
		logic               is_read;
		logic               is_write;
		logic               walk;
		logic [ADDR_W-1:0]  addr;
		logic [COUNT_W-1:0] rows;
		logic [COUNT_W-1:0] cols;
		walk_plan_t         plan;
	} dec_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		logic [CELL_W-1:0] data;
	} wr_t;

endpackage

@@ src/pcg_ram.sv @@
module pcg_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 3
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

@@ src/pcg_decode.sv @@
module pcg_decode (
	input  logic [pcg_pkg::FUNC_W-1:0]  func,
	input  pcg_pkg::in_word_t           word,
	input  logic [pcg_pkg::COUNT_W-1:0] rows,
	input  logic [pcg_pkg::COUNT_W-1:0] cols,
	output pcg_pkg::dec_t               dec
);

	localparam int AW = pcg_pkg::ADDR_W;
	localparam int CW = pcg_pkg::COUNT_W;
	localparam int IW = pcg_pkg::IDX_W;
	localparam int OW = pcg_pkg::OP_W;
	localparam int PW = pcg_pkg::PROD_W;

	logic [OW-1:0] rows_x;
	logic [OW-1:0] cols_x;
	logic [OW-1:0] rows_inc;
	logic [OW-1:0] cols_inc;
	logic [OW-1:0] op_a;
	logic [OW-1:0] op_b;
	logic [PW-1:0] prod;
	logic          over_cap;

	assign rows_x   = OW'(rows);
	assign cols_x   = OW'(cols);
	assign rows_inc = rows_x + OW'(1);
	assign cols_inc = cols_x + OW'(1);

	always_comb begin
		case (pcg_pkg::func_t'(func))
			pcg_pkg::FN_READ, pcg_pkg::FN_WRITE: begin
				op_a = OW'(word.row);
				op_b = cols_x;
			end
			pcg_pkg::FN_INIT: begin
				op_a = OW'(word.dim_rows);
				op_b = OW'(word.dim_cols);
			end
			pcg_pkg::FN_INS_ROW: begin
				op_a = rows_inc;
				op_b = cols_x;
			end
			pcg_pkg::FN_DEL_ROW: begin
				op_a = OW'(word.position);
				op_b = cols_x;
			end
			pcg_pkg::FN_INS_COL: begin
				op_a = rows_x;
				op_b = cols_inc;
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	assign prod     = op_a * op_b;
	assign over_cap = prod > PW'(pcg_pkg::MAX_CELLS);

	always_comb begin
		dec        = '0;
		dec.status = pcg_pkg::ST_OK;
		dec.rows   = rows;
		dec.cols   = cols;
		case (pcg_pkg::func_t'(func))
			pcg_pkg::FN_READ, pcg_pkg::FN_WRITE: begin
				if (CW'(word.row) >= rows || CW'(word.column) >= cols) begin
					dec.status = pcg_pkg::ST_BAD_COORD;
				end else begin
					dec.addr     = AW'(prod + PW'(word.column));
					dec.is_read  = (pcg_pkg::func_t'(func) == pcg_pkg::FN_READ);
					dec.is_write = (pcg_pkg::func_t'(func) == pcg_pkg::FN_WRITE);
				end
			end
			pcg_pkg::FN_INIT: begin
				if (word.dim_rows == '0 || word.dim_cols == '0 ||
				    word.dim_rows > CW'(pcg_pkg::MAX_DIM) ||
				    word.dim_cols > CW'(pcg_pkg::MAX_DIM)) begin
					dec.status = pcg_pkg::ST_BAD_COORD;
				end else if (over_cap) begin
					dec.status = pcg_pkg::ST_CAPACITY;
				end else begin
					dec.rows          = word.dim_rows;
					dec.cols          = word.dim_cols;
					dec.walk          = 1'b1;
					dec.plan.kind     = pcg_pkg::WK_CLEAR;
					dec.plan.desc     = 1'b0;
					dec.plan.r_start  = '0;
					dec.plan.r_end    = IW'(word.dim_rows - CW'(1));
					dec.plan.cn       = word.dim_cols;
					dec.plan.co       = word.dim_cols;
					dec.plan.fill     = '0;
				end
			end
			pcg_pkg::FN_INS_ROW: begin
				if (word.position > rows) begin
					dec.status = pcg_pkg::ST_BAD_POS;
				end else if (rows_inc > OW'(pcg_pkg::MAX_DIM) || over_cap) begin
					dec.status = pcg_pkg::ST_CAPACITY;
				end else begin
					dec.rows          = CW'(rows_inc);
					dec.walk          = (cols != '0);
					dec.plan.kind     = pcg_pkg::WK_INS_ROW;
					dec.plan.desc     = 1'b1;
					dec.plan.r_start  = IW'(rows);
					dec.plan.r_end    = IW'(word.position);
					dec.plan.cn       = cols;
					dec.plan.co       = cols;
					dec.plan.pos      = word.position;
					dec.plan.fill     = word.value;
					dec.plan.dst_base = AW'(prod - PW'(cols_x));
					dec.plan.src_base = AW'(prod - (PW'(cols_x) << 1));
				end
			end
			pcg_pkg::FN_DEL_ROW: begin
				if (word.position >= rows) begin
					dec.status = pcg_pkg::ST_BAD_POS;
				end else if (rows <= CW'(1)) begin
					dec.status = pcg_pkg::ST_LAST;
				end else begin
					dec.rows          = rows - CW'(1);
					dec.walk          = (cols != '0) && (word.position != rows - CW'(1));
					dec.plan.kind     = pcg_pkg::WK_DEL_ROW;
					dec.plan.desc     = 1'b0;
					dec.plan.r_start  = IW'(word.position);
					dec.plan.r_end    = IW'(rows - CW'(2));
					dec.plan.cn       = cols;
					dec.plan.co       = cols;
					dec.plan.pos      = word.position;
					dec.plan.dst_base = AW'(prod);
					dec.plan.src_base = AW'(prod + PW'(cols_x));
				end
			end
			pcg_pkg::FN_INS_COL: begin
				if (word.position > cols) begin
					dec.status = pcg_pkg::ST_BAD_POS;
				end else if (cols_inc > OW'(pcg_pkg::MAX_DIM) || over_cap) begin
					dec.status = pcg_pkg::ST_CAPACITY;
				end else begin
					dec.cols          = CW'(cols_inc);
					dec.walk          = (rows != '0);
					dec.plan.kind     = pcg_pkg::WK_INS_COL;
					dec.plan.desc     = 1'b1;
					dec.plan.r_start  = IW'(rows - CW'(1));
					dec.plan.r_end    = '0;
					dec.plan.cn       = CW'(cols_inc);
					dec.plan.co       = cols;
					dec.plan.pos      = word.position;
					dec.plan.fill     = word.value;
					dec.plan.dst_base = AW'(prod - PW'(cols_inc));
					dec.plan.src_base = AW'(prod - PW'(rows_x) - PW'(cols_x));
				end
			end
			pcg_pkg::FN_DEL_COL: begin
				if (word.position >= cols) begin
					dec.status = pcg_pkg::ST_BAD_POS;
				end else if (cols <= CW'(1)) begin
					dec.status = pcg_pkg::ST_LAST;
				end else begin
					dec.cols          = cols - CW'(1);
					dec.walk          = (rows != '0);
					dec.plan.kind     = pcg_pkg::WK_DEL_COL;
					dec.plan.desc     = 1'b0;
					dec.plan.r_start  = '0;
					dec.plan.r_end    = IW'(rows - CW'(1));
					dec.plan.cn       = cols - CW'(1);
					dec.plan.co       = cols;
					dec.plan.pos      = word.position;
				end
			end
			default: begin
				dec.status = pcg_pkg::ST_BAD_COORD;
			end
		endcase
	end

endmodule

@@ src/pcg_walk.sv @@
module pcg_walk (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        load,
	input  pcg_pkg::walk_plan_t         plan,
	input  logic                        step,
	input  logic [pcg_pkg::CELL_W-1:0]  rdata,
	output logic [pcg_pkg::ADDR_W-1:0]  rd_addr,
	output pcg_pkg::wr_t                wr,
	output logic                        last
);

	localparam int AW = pcg_pkg::ADDR_W;
	localparam int CW = pcg_pkg::COUNT_W;
	localparam int IW = pcg_pkg::IDX_W;

	pcg_pkg::walk_plan_t plan_q;
	logic [IW-1:0]       r_q;
	logic [IW-1:0]       c_q;
	logic [AW-1:0]       dst_base_q;
	logic [AW-1:0]       src_base_q;
	logic                valid_s1;
	logic [AW-1:0]       dst_s1;
	logic                fill_s1;

	logic [IW-1:0]       c_last;
	logic [CW-1:0]       c_x;
	logic [CW-1:0]       src_col;
	logic                is_fill;
	logic [AW-1:0]       dst_addr;

	assign c_last = IW'(plan_q.cn - CW'(1));
	assign c_x    = CW'(c_q);

	always_comb begin
		case (plan_q.kind)
			pcg_pkg::WK_INS_COL: begin
				src_col = (c_x > plan_q.pos) ? c_x - CW'(1) : c_x;
				is_fill = (c_x == plan_q.pos);
			end
			pcg_pkg::WK_DEL_COL: begin
				src_col = (c_x >= plan_q.pos) ? c_x + CW'(1) : c_x;
				is_fill = 1'b0;
			end
			pcg_pkg::WK_INS_ROW: begin
				src_col = c_x;
				is_fill = (CW'(r_q) == plan_q.pos);
			end
			pcg_pkg::WK_CLEAR: begin
				src_col = c_x;
				is_fill = 1'b1;
			end
			default: begin
				src_col = c_x;
				is_fill = 1'b0;
			end
		endcase
	end

	assign dst_addr = dst_base_q + AW'(c_q);
	assign rd_addr  = src_base_q + AW'(src_col);
	assign last     = (r_q == plan_q.r_end) && (plan_q.desc ? (c_q == '0) : (c_q == c_last));

	always_ff @(posedge clk) begin
		if (load) begin
			plan_q     <= plan;
			r_q        <= plan.r_start;
			c_q        <= plan.desc ? IW'(plan.cn - CW'(1)) : '0;
			dst_base_q <= plan.dst_base;
			src_base_q <= plan.src_base;
		end else if (step) begin
			if (plan_q.desc) begin
				if (c_q == '0) begin
					c_q        <= c_last;
					r_q        <= r_q - IW'(1);
					dst_base_q <= dst_base_q - AW'(plan_q.cn);
					src_base_q <= src_base_q - AW'(plan_q.co);
				end else begin
					c_q <= c_q - IW'(1);
				end
			end else begin
				if (c_q == c_last) begin
					c_q        <= '0;
					r_q        <= r_q + IW'(1);
					dst_base_q <= dst_base_q + AW'(plan_q.cn);
					src_base_q <= src_base_q + AW'(plan_q.co);
				end else begin
					c_q <= c_q + IW'(1);
				end
			end
		end
		if (step) begin
			dst_s1  <= dst_addr;
			fill_s1 <= is_fill;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= step;
		end
	end

	assign wr.en   = valid_s1;
	assign wr.addr = dst_s1;
	assign wr.data = fill_s1 ? plan_q.fill : rdata;

endmodule

@@ src/packed_cell_grid_row_col_edit.sv @@
// Grid of 3-bit cells kept row-major in one on-chip RAM, with its row and column counts.
// The input stream carries one operation per word: the opcode in s_tuser and the
// coordinates, position, value and dimensions in s_tdata. Each input word produces
// exactly one output word carrying the read value and the new counts, with the status
// in m_tuser.
// A write, or any operation that ends with a non-zero status or walks no cells, has its
// result loaded into the output register on the accepting edge. A read is loaded from
// S_READ, once the registered read data of the cell RAM is available.
// Init, and a row or column insert or delete, walk the cells of the new grid that change
// in place, one cell per cycle through the RAM's one read port and one write port. Init
// clears all rows*columns cells. s_tready is low during that walk.
// Reset clears the counts to an empty grid. The RAM gets no clearing pass, since every
// cell is written before it becomes part of the grid.
// m_tvalid holds a result until it is taken. A new word is accepted only while the
// output register is empty or draining in the same cycle, so a stalled receiver stops
// the input after one pending result.
module packed_cell_grid_row_col_edit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	// row, column, position, value, dim_rows, dim_cols
	input  logic [pcg_pkg::IN_W-1:0]     s_tdata,
	// func
	input  logic [pcg_pkg::FUNC_W-1:0]   s_tuser,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	// read_value, rows_now, cols_now
	output logic [pcg_pkg::OUT_W-1:0]    m_tdata,
	// status
	output logic [pcg_pkg::STATUS_W-1:0] m_tuser
);

	localparam int AW = pcg_pkg::ADDR_W;
	localparam int CW = pcg_pkg::COUNT_W;
	localparam int PW = pcg_pkg::PROD_W;
	localparam int VW = pcg_pkg::CELL_W;

	pcg_pkg::state_t   state_q;
	pcg_pkg::state_t   state_d;
	pcg_pkg::in_word_t in_w;
	pcg_pkg::dec_t     dec;
	pcg_pkg::wr_t      walk_wr;
	pcg_pkg::out_word_t out_q;
	pcg_pkg::status_t  out_status_q;

	logic [CW-1:0] rows_q;
	logic [CW-1:0] cols_q;
	logic          out_valid_q;
	logic          out_free;
	logic          in_acc;

	logic          walk_load;
	logic          walk_step;
	logic          walk_last;
	logic [AW-1:0] walk_rd_addr;

	logic          res_load;
	logic [VW-1:0] res_value;
	pcg_pkg::status_t res_status;
	logic [CW-1:0] res_rows;
	logic [CW-1:0] res_cols;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [VW-1:0] ram_wdata;
	logic [AW-1:0] ram_raddr;
	logic [VW-1:0] ram_rdata;

	assign in_w     = s_tdata;
	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == pcg_pkg::S_IDLE) && out_free;
	assign in_acc   = s_tvalid && s_tready;

	pcg_decode u_decode (
		.func (s_tuser),
		.word (in_w),
		.rows (rows_q),
		.cols (cols_q),
		.dec  (dec)
	);

	pcg_walk u_walk (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (walk_load),
		.plan    (dec.plan),
		.step    (walk_step),
		.rdata   (ram_rdata),
		.rd_addr (walk_rd_addr),
		.wr      (walk_wr),
		.last    (walk_last)
	);

	assign ram_we    = walk_wr.en || (in_acc && dec.is_write);
	assign ram_waddr = walk_wr.en ? walk_wr.addr : dec.addr;
	assign ram_wdata = walk_wr.en ? walk_wr.data : in_w.value;
	assign ram_raddr = (state_q == pcg_pkg::S_IDLE) ? dec.addr : walk_rd_addr;

	pcg_ram #(
		.DEPTH (pcg_pkg::MAX_CELLS),
		.WIDTH (VW)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		state_d = state_q;
		case (state_q)
			pcg_pkg::S_IDLE: begin
				if (in_acc && dec.is_read) begin
					state_d = pcg_pkg::S_READ;
				end else if (in_acc && dec.walk) begin
					state_d = pcg_pkg::S_WALK;
				end
			end
			pcg_pkg::S_READ: begin
				state_d = pcg_pkg::S_IDLE;
			end
			pcg_pkg::S_WALK: begin
				if (walk_last) begin
					state_d = pcg_pkg::S_DRAIN;
				end
			end
			pcg_pkg::S_DRAIN: begin
				state_d = pcg_pkg::S_IDLE;
			end
			default: begin
				state_d = pcg_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		walk_load  = 1'b0;
		walk_step  = 1'b0;
		res_load   = 1'b0;
		res_value  = '0;
		res_status = pcg_pkg::ST_OK;
		res_rows   = rows_q;
		res_cols   = cols_q;
		case (state_q)
			pcg_pkg::S_IDLE: begin
				walk_load  = in_acc && dec.walk;
				res_load   = in_acc && !dec.is_read && !dec.walk;
				res_status = dec.status;
				res_rows   = dec.rows;
				res_cols   = dec.cols;
			end
			pcg_pkg::S_READ: begin
				res_load  = 1'b1;
				res_value = ram_rdata;
			end
			pcg_pkg::S_WALK: begin
				walk_step = 1'b1;
			end
			pcg_pkg::S_DRAIN: begin
				res_load = 1'b1;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pcg_pkg::S_IDLE;
			rows_q      <= '0;
			cols_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (in_acc) begin
				rows_q <= dec.rows;
				cols_q <= dec.cols;
			end
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (res_load) begin
			out_q.pad        <= '0;
			out_q.read_value <= res_value;
			out_q.rows_now   <= res_rows;
			out_q.cols_now   <= res_cols;
			out_status_q     <= res_status;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;
	assign m_tuser  = out_status_q;

`ifndef NO_ASSERTIONS
	a_counts_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(rows_q <= CW'(pcg_pkg::MAX_DIM)) && (cols_q <= CW'(pcg_pkg::MAX_DIM)) &&
		((PW'(rows_q) * PW'(cols_q)) <= PW'(pcg_pkg::MAX_CELLS)))
		else $error("grid dimensions exceed the cell store");

	a_write_in_grid: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (PW'(ram_waddr) < (PW'(rows_q) * PW'(cols_q))))
		else $error("cell write outside the current grid");

	a_read_result: assert property (@(posedge clk) disable iff (!arst_n)
		(in_acc && dec.is_read) |-> ##2 (m_tvalid && m_tuser == pcg_pkg::ST_OK))
		else $error("read did not produce a result two cycles after acceptance");

	a_walk_counts_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcg_pkg::S_WALK) |=> ($stable(rows_q) && $stable(cols_q)))
		else $error("grid counts changed during a cell walk");

	a_drain_writes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == pcg_pkg::S_DRAIN) |-> ram_we)
		else $error("last walked cell was not written back");
`endif

endmodule
